/* src/fms_pkg.sv */
// ----------------------------------------------------------------------------
// Flight-mode sequencer package
// Shared types, codes and constants for the sequencer controller and datapath.
// ----------------------------------------------------------------------------
package fms_pkg;

	typedef enum logic [3:0] {
		MODE_INIT      = 4'd0,
		MODE_PREARM    = 4'd1,
		MODE_ARM       = 4'd2,
		MODE_PREFLY    = 4'd3,
		MODE_FLY       = 4'd4,
		MODE_DISARM    = 4'd5,
		MODE_AUTO      = 4'd6,
		MODE_TWIN      = 4'd7,
		MODE_FAILSAFE  = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_RADIO = 3'd1,
		ERR_IMU_ABS  = 3'd2,
		ERR_IMU_CAL  = 3'd3,
		ERR_NOT_ARM  = 3'd4,
		ERR_NO_FLY   = 3'd5,
		ERR_DELAY    = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		REG_THR_MIN   = 3'd0,
		REG_THR_MAX   = 3'd1,
		REG_PWM_MIN   = 3'd2,
		REG_PWM_IDLE  = 3'd3,
		REG_FS_LIMIT  = 3'd4,
		REG_DISARM    = 3'd5,
		REG_TWIN_RAMP = 3'd6,
		REG_TWIN_END  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		IMU_OK     = 2'd0,
		IMU_ABSENT = 2'd1
	} imu_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_EXEC,
		CS_DIV,
		CS_OUT
	} ctrl_state_t;

	localparam int CFG_W      = 12;
	localparam int NUM_W      = 21;
	localparam int REM_W      = 12;
	localparam int CNT_W      = 5;
	localparam int TW_W       = 19;
	localparam logic [10:0] SW_THRESHOLD  = 11'd1500;
	localparam logic [10:0] FLY_THR_LIMIT = 11'd400;
	localparam logic [9:0]  THR_FULL      = 10'd750;
	localparam logic [10:0] TW_SCALE      = 11'd200;
	localparam logic [TW_W-1:0] TW_MAX    = 19'd524287;
	// x/200 as (x>>3)/25: ceil(2^21/25), exact for any 16-bit x
	localparam int PROD_W                 = 33;
	localparam int RECIP_SH               = 21;
	localparam logic [16:0] DIV25_RECIP   = 17'd83887;

	typedef struct packed {
		logic exec;
		logic div_step;
		logic out_load;
	} fms_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} fms_stat_t;

endpackage

/* src/flight_mode_sequencer.sv */
// ----------------------------------------------------------------------------
// Flight-mode sequencer
// Radio-frame latching, link watchdog and flight-mode state machine.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ stream. s_tuser is the item kind: 0 is a
//   radio frame (latches switch flags, failsafe bit, scales throttle), 1 is
//   a control tick (runs the watchdog and one step of the mode machine).
//   Every item produces exactly one result item on the m_ stream.
//   A frame with throttle strictly between the raw limits passes through
//   one update step, the 21 steps of the bit-serial throttle divider, then
//   the output load; every other item, twin ticks included, goes from the
//   update step straight to the output load. Twin pulses divide by the
//   constant 200 through a reciprocal multiply at the output load.
//   One item is in work at a time, and a new item can be taken in the
//   cycle after the previous result is loaded into the output register.
//   If the receiver stalls, the finished result waits in the output register
//   while the next item is accepted and processed; that item's result then
//   holds until the register frees.
//   Configuration is written on cfg_we/cfg_index/cfg_data while idle.
//   Reset (arst_n low) restores the default registers, puts the mode in
//   init and clears the watchdog and mode counters, flags and the output valid.
// ----------------------------------------------------------------------------
module flight_mode_sequencer import fms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	// chan_arm, chan_fly, chan_throttle, chan_autofly, chan_twin,
	// failsafe_flag, imu_status (lowest first), zero fill
	input  logic [63:0]      s_tdata,
	// op
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// mode, mode_changed, error_code, angle_loop_due, throttle_cmd,
	// twin_pwm_high, twin_pwm_low (lowest first), zero fill
	output logic [47:0]      m_tdata
);

	fms_cmd_t  cmd;
	fms_stat_t stat;
	logic      in_load;

	// controller owns the handshakes and the step sequence
	fms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd),
		.in_load  (in_load)
	);

	// datapath holds all sequencer state and the throttle divider
	fms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_load   (in_load),
		.in_op     (s_tuser),
		.in_data   (s_tdata[57:0]),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

/* src/fms_ctrl.sv */
// ----------------------------------------------------------------------------
// Flight-mode sequencer controller
// Sequences item intake, the update step, the throttle divider and output load.
// ----------------------------------------------------------------------------
module fms_ctrl import fms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  fms_stat_t stat,
	output fms_cmd_t  cmd,
	output logic      in_load
);

	ctrl_state_t state_q, state_d;
	logic        m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		in_load  = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					in_load = 1'b1;
					state_d = CS_EXEC;
				end
			end
			CS_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_div ? CS_DIV : CS_OUT;
			end
			CS_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = CS_OUT;
			end
			CS_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

/* src/fms_dp.sv */
// ----------------------------------------------------------------------------
// Flight-mode sequencer datapath
// Config registers, mode state, twin ramp, bit-serial divider, output register.
// ----------------------------------------------------------------------------
module fms_dp import fms_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_load,
	input  logic             in_op,
	input  logic [57:0]      in_data,
	input  fms_cmd_t         cmd,
	output fms_stat_t        stat,
	output logic [47:0]      out_data
);

	// configuration
	logic [10:0] thr_min_q, thr_max_q;
	logic [11:0] pwm_min_q, pwm_idle_q;
	logic [7:0]  fs_limit_q;
	logic [8:0]  disarm_ticks_q;
	logic [11:0] ramp_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_min_q      <= 11'd368;
			thr_max_q      <= 11'd1680;
			pwm_min_q      <= 12'd1000;
			pwm_idle_q     <= 12'd1000;
			fs_limit_q     <= 8'd250;
			disarm_ticks_q <= 9'd400;
			ramp_q         <= 12'd2000;
			end_q          <= 12'd2200;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THR_MIN:   thr_min_q      <= cfg_data[10:0];
				REG_THR_MAX:   thr_max_q      <= cfg_data[10:0];
				REG_PWM_MIN:   pwm_min_q      <= cfg_data;
				REG_PWM_IDLE:  pwm_idle_q     <= cfg_data;
				REG_FS_LIMIT:  fs_limit_q     <= cfg_data[7:0];
				REG_DISARM:    disarm_ticks_q <= cfg_data[8:0];
				REG_TWIN_RAMP: ramp_q         <= cfg_data;
				REG_TWIN_END:  end_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// held input item
	logic        op_q;
	logic [57:0] in_q;
	always_ff @(posedge clk) begin
		if (in_load) begin
			op_q <= in_op;
			in_q <= in_data;
		end
	end

	logic [10:0] c_arm, c_fly, c_thr, c_auto, c_twin;
	logic        c_fs;
	logic [1:0]  c_imu;
	assign c_arm  = in_q[10:0];
	assign c_fly  = in_q[21:11];
	assign c_thr  = in_q[32:22];
	assign c_auto = in_q[43:33];
	assign c_twin = in_q[54:44];
	assign c_fs   = in_q[55];
	assign c_imu  = in_q[57:56];

	// state
	mode_t          mode_q, mode_d;
	logic [7:0]     llc_q, llc_d;
	logic           recv_q, recv_d, fs_q, fs_d;
	logic [3:0]     flags_q, flags_d;
	logic [9:0]     thr_q;
	logic [7:0]     flc_q, flc_d, alc_q, alc_d;
	logic [8:0]     dc_q, dc_d;
	logic [11:0]    tc_q, tc_d;
	logic [TW_W-1:0] hi_q, hi_d, lo_q, lo_d;

	// result fields of the step
	logic        chg_d, chg_q, due_d, due_q;
	err_t        err_d, err_q;
	logic        pwm_en_q;
	logic        need_frame_div, need_twin_div;

	// twin arithmetic on the current throttle
	logic [17:0] t200, t201;
	logic [18:0] t500;
	logic [12:0] t5;
	logic [TW_W-1:0] hi0, lo0, idle_off;
	logic [TW_W:0]   hi_add, lo_add;
	logic [12:0]     idle_diff;
	logic [20:0]     idle_mul;
	mode_t           m_eff;
	logic [7:0]      flc_inc, alc_inc;

	assign t200 = 18'(thr_q) * 18'(TW_SCALE);
	assign t201 = t200 + 18'(thr_q);
	assign t500 = 19'(thr_q) * 19'd500;
	assign t5   = 13'(thr_q) * 13'd5;
	assign hi0  = (tc_q == 12'd0) ? TW_W'(t200) : hi_q;
	assign lo0  = (tc_q == 12'd0) ? TW_W'(t200) : lo_q;
	assign hi_add = {1'b0, hi0} + (TW_W+1)'(t5);
	assign lo_add = {1'b0, lo0} + (TW_W+1)'(thr_q);
	assign idle_diff = {1'b0, pwm_idle_q} - {1'b0, pwm_min_q};
	assign idle_mul  = 21'(idle_diff[11:0]) * 21'(TW_SCALE);
	always_comb begin
		if (pwm_idle_q <= pwm_min_q) idle_off = '0;
		else if (idle_mul > 21'(TW_MAX)) idle_off = TW_MAX;
		else idle_off = idle_mul[TW_W-1:0];
	end
	assign flc_inc = flc_q + 8'd1;
	assign alc_inc = alc_q + 8'd1;

	always_comb begin
		mode_d  = mode_q;
		llc_d   = llc_q;
		recv_d  = recv_q;
		fs_d    = fs_q;
		flags_d = flags_q;
		flc_d   = flc_q;
		alc_d   = alc_q;
		dc_d    = dc_q;
		tc_d    = tc_q;
		hi_d    = hi_q;
		lo_d    = lo_q;
		chg_d   = 1'b0;
		due_d   = 1'b0;
		err_d   = ERR_NONE;
		m_eff   = mode_q;
		need_frame_div = 1'b0;
		need_twin_div  = 1'b0;
		if (!op_q) begin
			fs_d   = c_fs;
			recv_d = (c_arm != 11'd0);
			if (c_arm != 11'd0) llc_d = '0;
			flags_d    = {flags_q[3] | (c_twin > SW_THRESHOLD), c_auto > SW_THRESHOLD,
				(c_fly > SW_THRESHOLD) && (c_thr < FLY_THR_LIMIT), c_arm > SW_THRESHOLD};
			need_frame_div = (c_thr > thr_min_q) && (c_thr < thr_max_q);
		end else begin
			if (mode_q != MODE_INIT) begin
				if (llc_q != 8'hFF) llc_d = llc_q + 8'd1;
				if (fs_q || llc_d > fs_limit_q) m_eff = MODE_FAILSAFE;
			end
			mode_d = m_eff;
			unique case (m_eff)
				MODE_INIT: begin
					if (!recv_q) err_d = ERR_NO_RADIO;
					else if (c_imu == IMU_ABSENT) err_d = ERR_IMU_ABS;
					else if (c_imu != IMU_OK) err_d = ERR_IMU_CAL;
					else mode_d = MODE_PREARM;
				end
				MODE_PREARM: begin
					if (!flags_q[0]) err_d = ERR_NOT_ARM;
					else mode_d = MODE_ARM;
				end
				MODE_ARM: mode_d = MODE_PREFLY;
				MODE_PREFLY: begin
					if (!flags_q[0]) begin
						err_d  = ERR_NOT_ARM;
						mode_d = MODE_DISARM;
					end else if (!flags_q[1]) err_d = ERR_NO_FLY;
					else mode_d = MODE_FLY;
				end
				MODE_FLY: begin
					flc_d = flc_inc;
					if (!flags_q[0]) begin
						err_d = ERR_NOT_ARM; mode_d = MODE_DISARM; flc_d = '0;
					end else if (flags_q[2]) begin
						mode_d = MODE_AUTO; flc_d = '0;
					end else if (flags_q[3]) begin
						mode_d = MODE_TWIN; flc_d = '0;
					end else due_d = (flc_inc[1:0] == 2'd0);
				end
				MODE_AUTO: begin
					alc_d = alc_inc;
					if (!flags_q[0]) begin
						err_d = ERR_NOT_ARM; mode_d = MODE_DISARM; alc_d = '0;
					end else due_d = (alc_inc[1:0] == 2'd0);
				end
				MODE_TWIN: begin
					if (!flags_q[0]) begin
						err_d = ERR_NOT_ARM; mode_d = MODE_DISARM; tc_d = '0;
					end else begin
						hi_d = hi0;
						lo_d = lo0;
						if (tc_q > end_q) begin
							mode_d     = MODE_FLY;
							flags_d[3] = 1'b0;
							tc_d       = '0;
						end else begin
							if (tc_q > ramp_q) begin
								// converge both pairs back to the plain throttle
								hi_d = ({1'b0, hi0} >= (TW_W+1)'(t201)) ?
									hi0 - TW_W'(thr_q) : TW_W'(t200);
								lo_d = (lo_add > (TW_W+1)'(t200)) ? TW_W'(t200)
									: lo_add[TW_W-1:0];
							end else begin
								hi_d = (hi_add > (TW_W+1)'(t500)) ? t500
									: hi_add[TW_W-1:0];
								lo_d = (lo0 < TW_W'(thr_q)) ? idle_off
									: lo0 - TW_W'(thr_q);
							end
							if (tc_q != 12'hFFF) tc_d = tc_q + 12'd1;
							need_twin_div = 1'b1;
						end
					end
				end
				MODE_DISARM: begin
					if (dc_q < disarm_ticks_q) begin
						dc_d = dc_q + 9'd1; err_d = ERR_DELAY;
					end else begin
						dc_d = '0; mode_d = MODE_PREARM;
					end
				end
				MODE_FAILSAFE: ;
				default: mode_d = MODE_FAILSAFE;
			endcase
			chg_d = (mode_d != mode_q);
		end
	end

	// bit-serial restoring divider for the throttle scale, quotient builds up in num_q
	logic [NUM_W-1:0] num_q;
	logic [REM_W-1:0] rem_q;
	logic [10:0]      den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_sh;
	logic             qbit;
	logic [NUM_W-1:0] quot;

	assign rem_sh  = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign qbit    = (rem_sh >= REM_W'(den_q));
	assign quot    = {num_q[NUM_W-2:0], qbit};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rem_q <= '0;
			cnt_q <= CNT_W'(NUM_W - 1);
			num_q <= NUM_W'(c_thr - thr_min_q) * NUM_W'(THR_FULL);
			den_q <= thr_max_q - thr_min_q;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? rem_sh - REM_W'(den_q) : rem_sh;
			num_q <= quot;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign stat.need_div = need_frame_div;
	assign stat.div_last = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_INIT;
			llc_q   <= '0;
			recv_q  <= 1'b0;
			fs_q    <= 1'b0;
			flags_q <= '0;
			thr_q   <= '0;
			flc_q   <= '0;
			alc_q   <= '0;
			dc_q    <= '0;
			tc_q    <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
		end else begin
			if (cmd.exec) begin
				mode_q  <= mode_d;
				llc_q   <= llc_d;
				recv_q  <= recv_d;
				fs_q    <= fs_d;
				flags_q <= flags_d;
				flc_q   <= flc_d;
				alc_q   <= alc_d;
				dc_q    <= dc_d;
				tc_q    <= tc_d;
				hi_q    <= hi_d;
				lo_q    <= lo_d;
				if (!op_q) begin
					if (c_thr <= thr_min_q) thr_q <= '0;
					else if (c_thr >= thr_max_q) thr_q <= THR_FULL;
				end
			end else if (cmd.div_step && stat.div_last) begin
				thr_q <= quot[9:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			chg_q    <= chg_d;
			due_q    <= due_d;
			err_q    <= err_d;
			pwm_en_q <= need_twin_div;
		end
	end

	// twin pulses: divide the held ramp values by 200 with a reciprocal multiply
	logic [PROD_W-1:0] hi_prod, lo_prod;
	logic [12:0]       pwm_hi, pwm_lo;
	assign hi_prod = PROD_W'(hi_q[TW_W-1:3]) * PROD_W'(DIV25_RECIP);
	assign lo_prod = PROD_W'(lo_q[TW_W-1:3]) * PROD_W'(DIV25_RECIP);
	assign pwm_hi  = pwm_en_q ? 13'(pwm_min_q) + 13'(hi_prod[PROD_W-1:RECIP_SH]) : '0;
	assign pwm_lo  = pwm_en_q ? 13'(pwm_min_q) + 13'(lo_prod[PROD_W-1:RECIP_SH]) : '0;

	logic [47:0] out_q;
	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_q <= {3'b0, pwm_lo, pwm_hi, thr_q, due_q, err_q, chg_q, mode_q};
	end
	assign out_data = out_q;

endmodule

/* verif/flight_mode_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// Flight-mode sequencer testbench
// Drives radio frames and control ticks into the sequencer, predicts every
// result with a cycle-free model of the mode machine and compares them in
// order. Several register settings are visited, including the extremes.
// ----------------------------------------------------------------------------
module flight_mode_sequencer_tb;
	import fms_pkg::*;

	typedef struct {
		logic [3:0]  mode;
		logic        changed;
		logic [2:0]  err;
		logic        due;
		logic [9:0]  thr;
		logic [12:0] pwm_hi;
		logic [12:0] pwm_lo;
	} seq_result_t;

	// Sequencer state mirror plus the queue of results it has predicted
	class mode_scoreboard;
		int unsigned thr_min, thr_max, pwm_min, pwm_idle;
		int unsigned fs_limit, disarm_len, ramp_len, end_len;
		mode_t       cur_mode;
		int unsigned lost_cnt, rx_live, flags, fs_bit, thr;
		int unsigned fly_cnt, auto_cnt, disarm_cnt, twin_cnt, tw_hi, tw_lo;
		seq_result_t pending[$];
		int          errors;

		function new();
			thr_min = 368; thr_max = 1680; pwm_min = 1000; pwm_idle = 1000;
			fs_limit = 250; disarm_len = 400; ramp_len = 2000; end_len = 2200;
			cur_mode = MODE_INIT;
			lost_cnt = 0; rx_live = 0; flags = 0; fs_bit = 0; thr = 0;
			fly_cnt = 0; auto_cnt = 0; disarm_cnt = 0; twin_cnt = 0;
			tw_hi = 0; tw_lo = 0; errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, int unsigned value);
			int unsigned v;
			v = value & 12'hFFF;
			case (idx)
				REG_THR_MIN:   thr_min = v & 11'h7FF;
				REG_THR_MAX:   thr_max = v & 11'h7FF;
				REG_PWM_MIN:   pwm_min = v;
				REG_PWM_IDLE:  pwm_idle = v;
				REG_FS_LIMIT:  fs_limit = v & 8'hFF;
				REG_DISARM:    disarm_len = v & 9'h1FF;
				REG_TWIN_RAMP: ramp_len = v;
				REG_TWIN_END:  end_len = v;
			endcase
		endfunction

		// Note one accepted item and queue the result it causes
		function void note_item(bit op, logic [63:0] d);
			seq_result_t r;
			int unsigned arm, fly, raw, aut, twn, imu, offs;
			mode_t start, nxt;
			arm = d[10:0]; fly = d[21:11]; raw = d[32:22];
			aut = d[43:33]; twn = d[54:44]; imu = d[57:56];
			r = '{default: 0};
			if (!op) begin
				fs_bit = d[55];
				rx_live = (arm != 0);
				if (arm != 0) lost_cnt = 0;
				if (raw <= thr_min) thr = 0;
				else if (raw >= thr_max) thr = 750;
				else thr = (raw - thr_min) * 750 / (thr_max - thr_min);
				flags &= 8;
				if (arm > 1500) flags |= 1;
				if (fly > 1500 && raw < 400) flags |= 2;
				if (aut > 1500) flags |= 4;
				if (twn > 1500) flags |= 8;
				r.mode = cur_mode;
				r.thr = 10'(thr);
				pending.push_back(r);
				return;
			end
			start = cur_mode;
			if (cur_mode != MODE_INIT) begin
				if (lost_cnt < 255) lost_cnt++;
				if (fs_bit != 0 || lost_cnt > fs_limit) cur_mode = MODE_FAILSAFE;
			end
			nxt = cur_mode;
			case (cur_mode)
				MODE_INIT: begin
					if (!rx_live) r.err = ERR_NO_RADIO;
					else if (imu == IMU_ABSENT) r.err = ERR_IMU_ABS;
					else if (imu != IMU_OK) r.err = ERR_IMU_CAL;
					else nxt = MODE_PREARM;
				end
				MODE_PREARM: begin
					if (!(flags & 1)) r.err = ERR_NOT_ARM;
					else nxt = MODE_ARM;
				end
				MODE_ARM: nxt = MODE_PREFLY;
				MODE_PREFLY: begin
					if (!(flags & 1)) begin
						r.err = ERR_NOT_ARM; nxt = MODE_DISARM;
					end else if (!(flags & 2)) r.err = ERR_NO_FLY;
					else nxt = MODE_FLY;
				end
				MODE_FLY: begin
					fly_cnt = (fly_cnt + 1) & 8'hFF;
					if (!(flags & 1)) begin
						r.err = ERR_NOT_ARM; nxt = MODE_DISARM; fly_cnt = 0;
					end else if (flags & 4) begin
						nxt = MODE_AUTO; fly_cnt = 0;
					end else if (flags & 8) begin
						nxt = MODE_TWIN; fly_cnt = 0;
					end else r.due = ((fly_cnt & 3) == 0);
				end
				MODE_AUTO: begin
					auto_cnt = (auto_cnt + 1) & 8'hFF;
					if (!(flags & 1)) begin
						r.err = ERR_NOT_ARM; nxt = MODE_DISARM; auto_cnt = 0;
					end else r.due = ((auto_cnt & 3) == 0);
				end
				MODE_TWIN: begin
					if (!(flags & 1)) begin
						r.err = ERR_NOT_ARM; nxt = MODE_DISARM; twin_cnt = 0;
					end else begin
						if (twin_cnt == 0) begin
							tw_hi = thr * 200; tw_lo = thr * 200;
						end
						if (twin_cnt > end_len) begin
							nxt = MODE_FLY; flags &= ~32'd8; twin_cnt = 0;
						end else begin
							if (twin_cnt > ramp_len) begin
								tw_hi = (tw_hi >= thr * 201) ? tw_hi - thr : thr * 200;
								tw_lo += thr;
								if (tw_lo > thr * 200) tw_lo = thr * 200;
							end else begin
								tw_hi += 5 * thr;
								if (tw_hi > 500 * thr) tw_hi = 500 * thr;
								if (tw_lo < thr) begin
									// underflow: fall back to the idle pulse offset
									offs = (pwm_idle <= pwm_min) ? 0 : (pwm_idle - pwm_min) * 200;
									tw_lo = (offs > TW_MAX) ? TW_MAX : offs;
								end else tw_lo -= thr;
							end
							tw_hi &= TW_MAX;
							tw_lo &= TW_MAX;
							r.pwm_hi = 13'(pwm_min + tw_hi / 200);
							r.pwm_lo = 13'(pwm_min + tw_lo / 200);
							if (twin_cnt < 4095) twin_cnt++;
						end
					end
				end
				MODE_DISARM: begin
					if (disarm_cnt < disarm_len) begin
						disarm_cnt++; r.err = ERR_DELAY;
					end else begin
						disarm_cnt = 0; nxt = MODE_PREARM;
					end
				end
				MODE_FAILSAFE: ;
				default: nxt = MODE_FAILSAFE;
			endcase
			r.changed = (nxt != start);
			cur_mode = nxt;
			r.mode = cur_mode;
			r.thr = 10'(thr);
			pending.push_back(r);
		endfunction

		function void check(logic [47:0] d);
			seq_result_t e;
			bit bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", d);
				return;
			end
			e = pending.pop_front();
			bad = (d[3:0] !== e.mode) || (d[4] !== e.changed) || (d[7:5] !== e.err)
				|| (d[8] !== e.due) || (d[18:9] !== e.thr)
				|| (d[31:19] !== e.pwm_hi) || (d[44:32] !== e.pwm_lo);
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: exp mode %0d chg %0d err %0d due %0d thr %0d hi %0d lo %0d",
						e.mode, e.changed, e.err, e.due, e.thr, e.pwm_hi, e.pwm_lo);
					$display("          got mode %0d chg %0d err %0d due %0d thr %0d hi %0d lo %0d",
						d[3:0], d[4], d[7:5], d[8], d[18:9], d[31:19], d[44:32]);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	// chan_arm, chan_fly, chan_throttle, chan_autofly, chan_twin,
	// failsafe_flag, imu_status (lowest first), zero fill
	logic [63:0]      s_tdata;
	// op
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	// mode, mode_changed, error_code, angle_loop_due, throttle_cmd,
	// twin_pwm_high, twin_pwm_low (lowest first), zero fill
	logic [47:0]      m_tdata;

	mode_scoreboard sb;
	bit             no_idle;      // hold both sides busy for a stretch
	bit             allow_fs;     // let frames carry the receiver failsafe bit
	int             arm_off_pct;
	int unsigned    cycles;

	flight_mode_sequencer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Run limit: far beyond the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver side: stall at random about 30 percent of the time unless no_idle is set
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 30);
	end

	// Compare every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);
	end

	// Present one item, hold it until taken, then maybe idle
	task automatic send_item(bit op, logic [63:0] d);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, d);
		if (!no_idle && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(6, 1);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] frame(int arm, int fly, int thr, int aut, int twn,
		bit fs);
		logic [63:0] d;
		d = '0;
		d[10:0] = 11'(arm); d[21:11] = 11'(fly); d[32:22] = 11'(thr);
		d[43:33] = 11'(aut); d[54:44] = 11'(twn); d[55] = fs;
		return d;
	endfunction

	function automatic logic [63:0] tick(int imu, bit noise);
		logic [63:0] d;
		// unused fields carry random noise that the block must ignore
		d = noise ? {$urandom, $urandom} : '0;
		d[63:58] = '0;
		d[57:56] = 2'(imu);
		return d;
	endfunction

	// Wait until every prediction has come back, then cover the longest latency
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_regs(int tmin, int tmax, int pmin, int pidle, int fsl, int dis,
		int ramp, int tend);
		drain();
		write_reg(REG_THR_MIN, tmin);
		write_reg(REG_THR_MAX, tmax);
		write_reg(REG_PWM_MIN, pmin);
		write_reg(REG_PWM_IDLE, pidle);
		write_reg(REG_FS_LIMIT, fsl);
		write_reg(REG_DISARM, dis);
		write_reg(REG_TWIN_RAMP, ramp);
		write_reg(REG_TWIN_END, tend);
		cfg_we <= 1'b0;
	endtask

	// Random frame: mostly armed and live, random content elsewhere
	task automatic random_frame();
		int arm, fly, thr, aut, twn, r;
		r = $urandom_range(99);
		if (r < arm_off_pct / 2) arm = 0;
		else if (r < arm_off_pct) arm = $urandom_range(2047);
		else arm = $urandom_range(2047, 1501);
		fly = ($urandom_range(1)) ? $urandom_range(2047, 1501) : $urandom_range(2047);
		thr = ($urandom_range(99) < 35) ? $urandom_range(399) : $urandom_range(2047);
		aut = ($urandom_range(99) < 8) ? $urandom_range(2047, 1501) : $urandom_range(1500);
		twn = ($urandom_range(99) < 15) ? $urandom_range(2047, 1501) : $urandom_range(1500);
		send_item(1'b0, frame(arm, fly, thr, aut, twn,
			allow_fs && ($urandom_range(99) < 3)));
	endtask

	task automatic random_phase(int count);
		int imu;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 40) random_frame();
			else begin
				imu = ($urandom_range(99) < 85) ? 0 : $urandom_range(3);
				send_item(1'b1, tick(imu, 1'($urandom_range(1))));
			end
		end
	endtask

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tuser     = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		no_idle     = 1'b0;
		allow_fs    = 1'b0;
		arm_off_pct = 15;
		cycles      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: init errors, imu codes including the unknown one, climb to fly
		send_item(1'b1, tick(IMU_OK, 0));                  // no radio yet
		send_item(1'b0, frame(1, 0, 0, 0, 0, 0));          // live but not armed
		send_item(1'b1, tick(IMU_ABSENT, 0));
		send_item(1'b1, tick(2, 0));                       // calibration fault
		send_item(1'b1, tick(3, 0));                       // unknown status
		send_item(1'b1, tick(IMU_OK, 0));                  // to prearm
		send_item(1'b1, tick(IMU_OK, 0));                  // not armed
		send_item(1'b0, frame(2047, 2047, 2047, 0, 0, 0)); // full throttle, no fly
		send_item(1'b1, tick(IMU_OK, 0));                  // to arm
		send_item(1'b1, tick(IMU_OK, 0));                  // to prefly
		send_item(1'b1, tick(IMU_OK, 0));                  // fly not requested
		send_item(1'b0, frame(2047, 2047, 0, 0, 0, 0));    // zero throttle, fly
		send_item(1'b1, tick(IMU_OK, 0));                  // to fly
		send_item(1'b0, frame(1600, 1501, 399, 0, 0, 0));
		for (int i = 0; i < 4; i++) send_item(1'b1, tick(IMU_OK, 1));
		send_item(1'b0, frame(1600, 0, 1000, 0, 2047, 0)); // twin request
		send_item(1'b1, tick(IMU_OK, 0));
		send_item(1'b1, tick(IMU_OK, 0));
		send_item(1'b0, frame(1500, 0, 1000, 0, 0, 0));    // disarm at threshold
		send_item(1'b1, tick(IMU_OK, 0));
		send_item(1'b1, tick(IMU_OK, 0));

		random_phase(250);
		// short twin ramp, quick disarm, full-range throttle, idle offset saturates
		set_regs(0, 2047, 0, 4095, 60, 3, 5, 12);
		random_phase(350);
		no_idle = 1'b1;
		random_phase(250);
		no_idle = 1'b0;
		// inverted throttle limits, zero-length twin and disarm, no timeout
		set_regs(2047, 0, 4095, 0, 255, 0, 0, 0);
		arm_off_pct = 25;
		random_phase(300);
		// twin never ends, long disarm
		set_regs(500, 1200, 2000, 2100, 80, 511, 20, 4095);
		arm_off_pct = 10;
		random_phase(300);
		// tight watchdog and receiver failsafe bit: end in failsafe
		set_regs(368, 1680, 1000, 1000, 1, 400, 2000, 2200);
		allow_fs    = 1'b1;
		arm_off_pct = 40;
		random_phase(280);

		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* flight_mode_sequencer.f */
src/fms_pkg.sv
src/fms_ctrl.sv
src/fms_dp.sv
src/flight_mode_sequencer.sv
verif/flight_mode_sequencer_tb.sv
